/* hw/rtl/tswdt_pkg.sv */
// Shared types, codes and constants of the two-stage watchdog timer.
package tswdt_pkg;

  // Preload register width and tick counter width (a stage can run twice the preload)
  localparam int PRELOAD_BITS = 32;
  localparam int TICK_W       = PRELOAD_BITS + 1;
  localparam int DPRE_W       = 21;
  localparam int CFG_AW       = 3;

  // Item function codes
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_WIN_WR  = 3'd1;
  localparam logic [2:0] FUNC_WIN_RD  = 3'd2;
  localparam logic [2:0] FUNC_CTRL_WR = 3'd3;
  localparam logic [2:0] FUNC_LOCK_WR = 3'd4;
  localparam logic [2:0] FUNC_CTRL_RD = 3'd5;
  localparam logic [2:0] FUNC_LOCK_RD = 3'd6;

  // Window byte offsets
  localparam logic [3:0] OFS_PRELOAD1 = 4'd0;
  localparam logic [3:0] OFS_PRELOAD2 = 4'd4;
  localparam logic [3:0] OFS_STATUS   = 4'd8;
  localparam logic [3:0] OFS_RELOAD   = 4'd12;

  // Expiry events reported on the result
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_RESET    = 3'd1;
  localparam logic [2:0] EV_POWEROFF = 3'd2;
  localparam logic [2:0] EV_NMI      = 3'd3;
  localparam logic [2:0] EV_NOTIFY   = 3'd4;

  // Stage-two actions
  localparam logic [1:0] ACT_RESET    = 2'd0;
  localparam logic [1:0] ACT_POWEROFF = 2'd1;
  localparam logic [1:0] ACT_NMI      = 2'd2;
  localparam logic [1:0] ACT_NOTIFY   = 2'd3;

  // Configuration register indexes
  localparam logic REG_ACTION  = 1'b0;
  localparam logic REG_PRELOAD = 1'b1;

  // Unlock sequence progress
  localparam logic [1:0] UNLK_IDLE  = 2'd0;
  localparam logic [1:0] UNLK_FIRST = 2'd1;
  localparam logic [1:0] UNLK_DONE  = 2'd2;

  // Register bit constants
  localparam logic [15:0] UNLOCK_KEY1  = 16'h0080;
  localparam logic [15:0] UNLOCK_KEY2  = 16'h0086;
  localparam int          RELOAD_BIT   = 8;
  localparam logic [31:0] FIRED_READ   = 32'h0000_0200;
  localparam logic [5:0]  CTRL_MASK    = 6'h27;
  localparam logic [1:0]  INTTYPE_NONE = 2'd3;
  localparam int          CTRL_PRESCALE_BIT = 2;
  localparam int          LOCK_LOCKED_BIT   = 0;
  localparam int          LOCK_ENABLE_BIT   = 1;
  localparam logic [DPRE_W-1:0] DPRE_RESET = 21'd30720;

  // Input item
  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  offset;
    logic [31:0] wdata;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_line;
    logic [2:0]  expiry_event;
    logic        counting;
  } out_item_t;

  // Configuration handed from the register port to the watchdog core
  typedef struct packed {
    logic [1:0]        action;
    logic              preload_load;
    logic [DPRE_W-1:0] preload_val;
  } cfg_t;

endpackage

/* hw/rtl/tswdt_cfg.sv */
// APB-style configuration registers: stage-two action and default preload.
module tswdt_cfg
  import tswdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [1:0]        action_r;
  logic [DPRE_W-1:0] dpre_r;
  logic              wr_en;
  logic              reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_r <= ACT_RESET;
      dpre_r   <= DPRE_RESET;
    end else if (wr_en) begin
      if (reg_idx == REG_ACTION) begin
        action_r <= cfg_pwdata[1:0];
      end else begin
        dpre_r <= cfg_pwdata[DPRE_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_ACTION:  cfg_prdata = {30'd0, action_r};
      REG_PRELOAD: cfg_prdata = {{(32-DPRE_W){1'b0}}, dpre_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Preload write also reloads both preload registers in the core
  assign cfg.action       = action_r;
  assign cfg.preload_load = wr_en & (reg_idx == REG_PRELOAD);
  assign cfg.preload_val  = cfg_pwdata[DPRE_W-1:0];

endmodule

/* hw/rtl/tswdt_core.sv */
// Watchdog state and the per-item update: ticks, window, control and lock accesses.
module tswdt_core
  import tswdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  logic [PRELOAD_BITS-1:0] pre1_r, pre1_nxt;
  logic [PRELOAD_BITS-1:0] pre2_r, pre2_nxt;
  logic [5:0]              ctrl_r, ctrl_nxt;
  logic [1:0]              lock_r, lock_nxt;
  logic                    status_r, status_nxt;
  logic                    armed_r, armed_nxt;
  logic                    stage2_r, stage2_nxt;
  logic                    fired_r, fired_nxt;
  logic [1:0]              unlk_r, unlk_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic                    irq_r, irq_nxt;
  logic [31:0]             rdata;
  logic [2:0]              event_code;
  logic [1:0]              lock_v;
  logic [15:0]             reload_v;
  logic [31:0]             dpre_ext;
  logic [31:0]             dpre_rst_ext;

  // Length of a stage in ticks
  function automatic logic [TICK_W-1:0] stage_ticks(input logic [PRELOAD_BITS-1:0] p,
                                                    input logic ps);
    logic [TICK_W-1:0] t;
    t = (p == '0) ? TICK_W'(1) : {1'b0, p};
    if (ps) t = {t[TICK_W-2:0], 1'b0};
    return t;
  endfunction

  assign dpre_ext     = {{(32-DPRE_W){1'b0}}, cfg.preload_val};
  assign dpre_rst_ext = {{(32-DPRE_W){1'b0}}, DPRE_RESET};
  assign reload_v     = item.wdata[15:0];

  // Compute the next state and the result of one item
  always_comb begin
    pre1_nxt   = pre1_r;
    pre2_nxt   = pre2_r;
    ctrl_nxt   = ctrl_r;
    lock_nxt   = lock_r;
    status_nxt = status_r;
    armed_nxt  = armed_r;
    stage2_nxt = stage2_r;
    fired_nxt  = fired_r;
    unlk_nxt   = unlk_r;
    tick_nxt   = tick_r;
    irq_nxt    = irq_r;
    rdata      = 32'd0;
    event_code = EV_NONE;
    lock_v     = item.wdata[1:0];

    case (item.func)
      FUNC_TICK: begin
        if (armed_r) begin
          if (tick_r[TICK_W-1:1] != '0) begin
            tick_nxt = tick_r - TICK_W'(1);
          end else if (!stage2_r) begin
            // stage one ran out: flag, interrupt, load stage two
            fired_nxt  = 1'b1;
            status_nxt = 1'b1;
            if (ctrl_r[1:0] != INTTYPE_NONE) irq_nxt = 1'b1;
            stage2_nxt = 1'b1;
            tick_nxt   = stage_ticks(pre2_r, ctrl_r[CTRL_PRESCALE_BIT]);
          end else begin
            // stage two ran out: issue the action
            case (cfg.action)
              ACT_NMI: begin
                event_code = EV_NMI;
                stage2_nxt = 1'b0;
                fired_nxt  = 1'b0;
                status_nxt = 1'b0;
                irq_nxt    = 1'b0;
                tick_nxt   = stage_ticks(pre1_r, ctrl_r[CTRL_PRESCALE_BIT]);
              end
              default: begin
                case (cfg.action)
                  ACT_RESET:    event_code = EV_RESET;
                  ACT_POWEROFF: event_code = EV_POWEROFF;
                  default:      event_code = EV_NOTIFY;
                endcase
                armed_nxt = 1'b0;
                irq_nxt   = 1'b0;
                tick_nxt  = '0;
              end
            endcase
          end
        end
      end

      FUNC_WIN_WR: begin
        case (item.offset)
          OFS_PRELOAD1: begin
            if (unlk_r == UNLK_DONE) begin
              pre1_nxt = item.wdata[PRELOAD_BITS-1:0];
              unlk_nxt = UNLK_IDLE;
            end
          end
          OFS_PRELOAD2: begin
            if (unlk_r == UNLK_DONE) begin
              pre2_nxt = item.wdata[PRELOAD_BITS-1:0];
              unlk_nxt = UNLK_IDLE;
            end
          end
          OFS_STATUS: begin
            if (item.wdata[0]) begin
              status_nxt = 1'b0;
              irq_nxt    = 1'b0;
            end
          end
          OFS_RELOAD: begin
            // advance the unlock sequence or pet
            if (reload_v == UNLOCK_KEY1) begin
              unlk_nxt = UNLK_FIRST;
            end else if (reload_v == UNLOCK_KEY2 && unlk_r == UNLK_FIRST) begin
              unlk_nxt = UNLK_DONE;
            end else begin
              if (unlk_r == UNLK_DONE && reload_v[RELOAD_BIT] && armed_r) begin
                stage2_nxt = 1'b0;
                fired_nxt  = 1'b0;
                status_nxt = 1'b0;
                irq_nxt    = 1'b0;
                tick_nxt   = stage_ticks(pre1_r, ctrl_r[CTRL_PRESCALE_BIT]);
              end
              unlk_nxt = UNLK_IDLE;
            end
          end
          default: ;
        endcase
      end

      FUNC_WIN_RD: begin
        case (item.offset)
          OFS_PRELOAD1: rdata = 32'(pre1_r);
          OFS_PRELOAD2: rdata = 32'(pre2_r);
          OFS_STATUS:   rdata = {31'd0, status_r};
          OFS_RELOAD:   rdata = fired_r ? FIRED_READ : 32'd0;
          default:      rdata = 32'd0;
        endcase
      end

      FUNC_CTRL_WR: begin
        if (!lock_r[LOCK_LOCKED_BIT]) ctrl_nxt = item.wdata[5:0] & CTRL_MASK;
      end

      FUNC_LOCK_WR: begin
        // locked makes both bits sticky
        if (lock_r[LOCK_LOCKED_BIT]) lock_v = lock_v | lock_r;
        lock_nxt = lock_v;
        if (!lock_r[LOCK_ENABLE_BIT] && lock_v[LOCK_ENABLE_BIT]) begin
          armed_nxt  = 1'b1;
          stage2_nxt = 1'b0;
          fired_nxt  = 1'b0;
          status_nxt = 1'b0;
          irq_nxt    = 1'b0;
          tick_nxt   = stage_ticks(pre1_r, ctrl_r[CTRL_PRESCALE_BIT]);
        end else if (lock_r[LOCK_ENABLE_BIT] && !lock_v[LOCK_ENABLE_BIT]) begin
          armed_nxt = 1'b0;
          irq_nxt   = 1'b0;
          tick_nxt  = '0;
        end
      end

      FUNC_CTRL_RD: rdata = {26'd0, ctrl_r};
      FUNC_LOCK_RD: rdata = {30'd0, lock_r};
      default: ;
    endcase
  end

  // Hold state; commit on each processed item, reload preloads on config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre1_r   <= dpre_rst_ext[PRELOAD_BITS-1:0];
      pre2_r   <= dpre_rst_ext[PRELOAD_BITS-1:0];
      ctrl_r   <= '0;
      lock_r   <= '0;
      status_r <= 1'b0;
      armed_r  <= 1'b0;
      stage2_r <= 1'b0;
      fired_r  <= 1'b0;
      unlk_r   <= UNLK_IDLE;
      tick_r   <= '0;
      irq_r    <= 1'b0;
    end else if (cfg.preload_load) begin
      pre1_r <= dpre_ext[PRELOAD_BITS-1:0];
      pre2_r <= dpre_ext[PRELOAD_BITS-1:0];
    end else if (step) begin
      pre1_r   <= pre1_nxt;
      pre2_r   <= pre2_nxt;
      ctrl_r   <= ctrl_nxt;
      lock_r   <= lock_nxt;
      status_r <= status_nxt;
      armed_r  <= armed_nxt;
      stage2_r <= stage2_nxt;
      fired_r  <= fired_nxt;
      unlk_r   <= unlk_nxt;
      tick_r   <= tick_nxt;
      irq_r    <= irq_nxt;
    end
  end

  assign res.rdata        = rdata;
  assign res.irq_line     = irq_nxt;
  assign res.expiry_event = event_code;
  assign res.counting     = armed_nxt;

endmodule

/* hw/rtl/two_stage_watchdog_timer.sv */
// Two-stage watchdog timer: top level with input and result registers.
// Each input beat is one tick of the 1024 Hz count clock or one register access, and
// produces exactly one result beat. The block takes one beat per cycle when the result side
// keeps up: a beat lands in the input register, is processed by the watchdog core (one
// compare and one decrement of the tick counter at most) once the result register is free,
// and its result is held in the result register. Under output backpressure the result
// register holds, and the input register stalls once it holds a beat. The APB-style port
// holds the stage-two action (address 0) and the default preload (address 4); writing the
// default preload also loads both preloads.
module two_stage_watchdog_timer
  import tswdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t res;
  cfg_t      cfg;
  logic      step;

  // Process the held beat when the result register is free or draining
  assign step     = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | step;

  // Hold the incoming beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tswdt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tswdt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

endmodule

/* dv/tb_two_stage_watchdog_timer.sv */
// Testbench of the two-stage watchdog timer: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

import tswdt_pkg::*;

localparam int SHOW_LIMIT = 10;

// Track watchdog state per accepted beat and check every result beat against it.
class watchdog_tracker;
  bit [1:0]              action;
  bit [DPRE_W-1:0]       dflt_preload;
  bit [PRELOAD_BITS-1:0] preload1;
  bit [PRELOAD_BITS-1:0] preload2;
  bit [5:0]              ctrl;
  bit [1:0]              lock_state;
  bit                    status_pend;
  bit                    armed;
  bit                    in_stage2;
  bit                    fired;
  bit                    irq;
  bit [1:0]              unlock;
  bit [TICK_W-1:0]       ticks_left;
  out_item_t             expected_results[$];
  int                    mismatches;
  int                    results_checked;
  int                    readbacks;
  int                    stage1_expiries;
  int                    stage2_actions;

  function new();
    action       = ACT_RESET;
    dflt_preload = DPRE_RESET;
    preload1     = PRELOAD_BITS'(DPRE_RESET);
    preload2     = preload1;
  endfunction

  // Length of a stage: at least one tick, doubled by prescale.
  function bit [TICK_W-1:0] stage_length(bit [PRELOAD_BITS-1:0] p);
    bit [TICK_W-1:0] t;
    t = (p != 0) ? TICK_W'(p) : TICK_W'(1);
    if (ctrl[CTRL_PRESCALE_BIT]) t = t << 1;
    return t;
  endfunction

  function void pet();
    in_stage2   = 1'b0;
    fired       = 1'b0;
    status_pend = 1'b0;
    irq         = 1'b0;
    ticks_left  = stage_length(preload1);
  endfunction

  function void halt();
    armed      = 1'b0;
    irq        = 1'b0;
    ticks_left = '0;
  endfunction

  // Advance to stage two, or carry out the stage-two action.
  function bit [2:0] expire();
    bit [2:0] ev;
    ev = EV_NONE;
    if (!in_stage2) begin
      fired       = 1'b1;
      status_pend = 1'b1;
      if (ctrl[1:0] != INTTYPE_NONE) irq = 1'b1;
      in_stage2  = 1'b1;
      ticks_left = stage_length(preload2);
      stage1_expiries++;
    end else begin
      stage2_actions++;
      case (action)
        ACT_RESET: begin
          halt();
          ev = EV_RESET;
        end
        ACT_POWEROFF: begin
          halt();
          ev = EV_POWEROFF;
        end
        ACT_NMI: begin
          pet();
          ev = EV_NMI;
        end
        default: begin
          halt();
          ev = EV_NOTIFY;
        end
      endcase
    end
    return ev;
  endfunction

  // Walk the unlock sequence; a completed sequence plus the reload bit pets.
  function void reload_write(bit [15:0] v);
    if (v == UNLOCK_KEY1) begin
      unlock = UNLK_FIRST;
    end else if (v == UNLOCK_KEY2 && unlock == UNLK_FIRST) begin
      unlock = UNLK_DONE;
    end else begin
      if (unlock == UNLK_DONE && v[RELOAD_BIT] && armed) pet();
      unlock = UNLK_IDLE;
    end
  endfunction

  // Keep lock bits sticky once locked; arm on a rising enable, stop on a falling one.
  function void lock_write(bit [1:0] v);
    bit was_en;
    was_en = lock_state[LOCK_ENABLE_BIT];
    if (lock_state[LOCK_LOCKED_BIT]) v |= lock_state;
    lock_state = v;
    if (!was_en && v[LOCK_ENABLE_BIT]) begin
      armed = 1'b1;
      pet();
    end else if (was_en && !v[LOCK_ENABLE_BIT]) begin
      halt();
    end
  endfunction

  // Apply one accepted input beat and queue the result it must produce.
  function void take_access(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.func)
      FUNC_TICK: begin
        if (armed) begin
          if (ticks_left != 0) ticks_left--;
          if (ticks_left == 0) r.expiry_event = expire();
        end
      end
      FUNC_WIN_WR: begin
        case (it.offset)
          OFS_PRELOAD1: begin
            if (unlock == UNLK_DONE) begin
              preload1 = it.wdata[PRELOAD_BITS-1:0];
              unlock   = UNLK_IDLE;
            end
          end
          OFS_PRELOAD2: begin
            if (unlock == UNLK_DONE) begin
              preload2 = it.wdata[PRELOAD_BITS-1:0];
              unlock   = UNLK_IDLE;
            end
          end
          OFS_STATUS: begin
            if (it.wdata[0]) begin
              status_pend = 1'b0;
              irq         = 1'b0;
            end
          end
          OFS_RELOAD: reload_write(it.wdata[15:0]);
          default: ;
        endcase
      end
      FUNC_WIN_RD: begin
        case (it.offset)
          OFS_PRELOAD1: r.rdata = 32'(preload1);
          OFS_PRELOAD2: r.rdata = 32'(preload2);
          OFS_STATUS:   r.rdata = 32'(status_pend);
          OFS_RELOAD:   r.rdata = fired ? FIRED_READ : '0;
          default: ;
        endcase
      end
      FUNC_CTRL_WR: begin
        if (!lock_state[LOCK_LOCKED_BIT]) ctrl = it.wdata[5:0] & CTRL_MASK;
      end
      FUNC_LOCK_WR: lock_write(it.wdata[1:0]);
      FUNC_CTRL_RD: r.rdata = 32'(ctrl);
      FUNC_LOCK_RD: r.rdata = 32'(lock_state);
      default: ;
    endcase
    r.irq_line = irq;
    r.counting = armed;
    expected_results.push_back(r);
  endfunction

  // Compare a result beat with the oldest expectation.
  function void compare_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("ERROR: result %0d arrived with nothing expected (got %h)",
                 results_checked, got);
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("ERROR: result %0d expected rdata=%h irq=%b event=%0d counting=%b,",
                   results_checked, want.rdata, want.irq_line, want.expiry_event,
                   want.counting);
          $display("       got rdata=%h irq=%b event=%0d counting=%b",
                   got.rdata, got.irq_line, got.expiry_event, got.counting);
        end
      end
    end
    results_checked++;
  endfunction

  function void write_register(logic idx, logic [31:0] value);
    if (idx == REG_ACTION) begin
      action = value[1:0];
    end else begin
      dflt_preload = value[DPRE_W-1:0];
      preload1     = PRELOAD_BITS'(dflt_preload);
      preload2     = preload1;
    end
  endfunction

  function void check_register(logic idx, logic [31:0] got);
    logic [31:0] want;
    want = (idx == REG_ACTION) ? 32'(action) : 32'(dflt_preload);
    readbacks++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("ERROR: register %0d read back %h, expected %h", idx, got, want);
    end
  endfunction
endclass

module tb_two_stage_watchdog_timer
  import tswdt_pkg::*;
;
  localparam logic [2:0] FUNC_UNUSED  = 3'd7;
  localparam int         LATENCY      = 2;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         PHASES       = 6;
  localparam int         PHASE_BEATS  = 280;
  localparam int         STALL_AT     = 500;
  localparam int         STALL_CYCLES = 400;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  watchdog_tracker tracker = new();
  int unsigned     beats_sent;
  int unsigned     cycle_count;
  bit              tx_gaps = 1'b1;

  two_stage_watchdog_timer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until accepted.
  task automatic send(input logic [2:0] f, input logic [3:0] ofs, input logic [31:0] wd);
    int unsigned gap;
    in_item_t    it;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 47) == 0) tx_gaps = !tx_gaps;
    it.func   = f;
    it.offset = ofs;
    it.wdata  = wd;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_access(it);
    beats_sent++;
  endtask

  task automatic unlock_window();
    send(FUNC_WIN_WR, OFS_RELOAD, {16'($urandom), UNLOCK_KEY1});
    send(FUNC_WIN_WR, OFS_RELOAD, {16'($urandom), UNLOCK_KEY2});
  endtask

  task automatic load_preload(input logic [3:0] ofs, input logic [31:0] value);
    unlock_window();
    send(FUNC_WIN_WR, ofs, value);
  endtask

  task automatic pet_watchdog();
    unlock_window();
    send(FUNC_WIN_WR, OFS_RELOAD, {16'($urandom), 16'($urandom) | (16'd1 << RELOAD_BIT)});
  endtask

  function automatic logic [31:0] lock_word(input bit en, input bit allow_lock);
    logic [31:0] w;
    w = $urandom;
    w[LOCK_ENABLE_BIT] = en;
    w[LOCK_LOCKED_BIT] = allow_lock && ($urandom_range(0, 11) == 0);
    return w;
  endfunction

  // Drop enable, then raise it to arm a fresh stage one.
  task automatic toggle_enable(input bit allow_lock);
    send(FUNC_LOCK_WR, 4'($urandom), lock_word(1'b0, allow_lock));
    send(FUNC_LOCK_WR, 4'($urandom), lock_word(1'b1, allow_lock));
  endtask

  // Release the input and wait until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Write a configuration register, then read it back.
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [CFG_AW-1:0] addr;
    addr = CFG_AW'(idx) << 2;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.write_register(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.check_register(idx, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed unlock, preload, arm and tick sequences, with some noise.
  task automatic run_random_phase(input int unsigned budget, input bit allow_lock);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    goal = beats_sent + budget;
    while (beats_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        n = $urandom_range(1, 8);
        repeat (n) send(FUNC_TICK, 4'($urandom), $urandom);
      end else if (pick < 48) begin
        load_preload($urandom_range(0, 1) ? OFS_PRELOAD2 : OFS_PRELOAD1,
                     ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12));
      end else if (pick < 58) begin
        pet_watchdog();
      end else if (pick < 63) begin
        send(FUNC_WIN_WR, OFS_STATUS, $urandom);
      end else if (pick < 67) begin
        send(FUNC_CTRL_WR, 4'($urandom), $urandom);
      end else if (pick < 76) begin
        if ($urandom_range(0, 2) == 0)
          send(FUNC_LOCK_WR, 4'($urandom), lock_word(1'($urandom_range(0, 1)), allow_lock));
        else
          toggle_enable(allow_lock);
      end else if (pick < 86) begin
        case ($urandom_range(0, 2))
          0: send(FUNC_WIN_RD,
                  ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3) << 2),
                  $urandom);
          1: send(FUNC_CTRL_RD, 4'($urandom), $urandom);
          default: send(FUNC_LOCK_RD, 4'($urandom), $urandom);
        endcase
      end else begin
        case ($urandom_range(0, 6))
          0: send(FUNC_WIN_WR, OFS_RELOAD, $urandom);
          1: begin
            send(FUNC_WIN_WR, OFS_RELOAD, {16'($urandom), UNLOCK_KEY1});
            send(FUNC_WIN_WR, OFS_RELOAD, $urandom);
          end
          2: send(FUNC_WIN_WR, OFS_RELOAD, {16'($urandom), UNLOCK_KEY2});
          3: send(FUNC_WIN_WR, $urandom_range(0, 1) ? OFS_PRELOAD2 : OFS_PRELOAD1, $urandom);
          4: send(FUNC_WIN_WR, 4'($urandom_range(0, 3) << 2) | 4'($urandom_range(1, 3)),
                  $urandom);
          5: send(FUNC_UNUSED, 4'($urandom), $urandom);
          default: begin
            // complete the sequence but leave the reload bit clear
            unlock_window();
            send(FUNC_WIN_WR, OFS_RELOAD, {16'($urandom), 16'($urandom) & 16'hFE7F});
          end
        endcase
      end
    end
  endtask

  // Accept results after random stalls, with one long hold-off to back up the block.
  initial begin : result_sink
    int unsigned gap;
    bit          rx_gaps;
    rx_gaps = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_gaps ? $urandom_range(0, 15) : 0;
      if ($urandom_range(0, 39) == 0) rx_gaps = !rx_gaps;
      if (tracker.results_checked == STALL_AT) gap = STALL_CYCLES;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.compare_result(out_data);
    end
  end

  initial begin : stimulus
    logic [31:0] act_word;
    logic [31:0] preload_word;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Check reset values, then run both stages out with the shortest preloads.
    send(FUNC_LOCK_RD, 4'hF, 32'hFFFF_FFFF);
    send(FUNC_CTRL_RD, 4'h0, 32'h0);
    send(FUNC_WIN_RD, OFS_PRELOAD1, 32'h0);
    send(FUNC_WIN_RD, OFS_RELOAD, 32'h0);
    send(FUNC_TICK, 4'hF, 32'hFFFF_FFFF);
    send(FUNC_WIN_WR, OFS_PRELOAD1, 32'hFFFF_FFFF);
    load_preload(OFS_PRELOAD1, 32'h0);
    load_preload(OFS_PRELOAD2, 32'h1);
    send(FUNC_CTRL_WR, 4'h0, 32'hFFFF_FFFF);
    send(FUNC_LOCK_WR, 4'h0, 32'h0000_0002);
    repeat (4) send(FUNC_TICK, 4'h0, 32'h0);
    send(FUNC_WIN_RD, OFS_RELOAD, 32'h0);
    send(FUNC_WIN_RD, OFS_STATUS, 32'h0);
    send(FUNC_WIN_WR, OFS_STATUS, 32'h1);
    // enable is still set after the stop, so this must not rearm
    send(FUNC_LOCK_WR, 4'h0, 32'h0000_0002);
    send(FUNC_WIN_WR, 4'h3, 32'hFFFF_FFFF);
    send(FUNC_UNUSED, 4'hF, 32'hFFFF_FFFF);
    settle();

    // Step through every action and the preload extremes; lock only in the last phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      act_word = $urandom;
      act_word[1:0] = (phase < 4) ? 2'(phase) : 2'($urandom);
      case (phase)
        0: preload_word = 32'd1024;
        1: preload_word = 32'd2095104;
        2: preload_word = 32'(DPRE_RESET);
        default: preload_word = $urandom_range(1024, 2095104);
      endcase
      set_register(REG_ACTION, act_word);
      set_register(REG_PRELOAD, preload_word);
      run_random_phase(PHASE_BEATS, phase == PHASES - 1);
      settle();
    end

    $display("Sent %0d beats over %0d configuration settings; %0d register read-backs.",
             beats_sent, PHASES, tracker.readbacks);
    $display("Saw %0d stage-one expiries and %0d stage-two actions in %0d results.",
             tracker.stage1_expiries, tracker.stage2_actions, tracker.results_checked);
    if (tracker.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

/* two_stage_watchdog_timer.f */
hw/rtl/tswdt_pkg.sv
hw/rtl/tswdt_cfg.sv
hw/rtl/tswdt_core.sv
hw/rtl/two_stage_watchdog_timer.sv
dv/tb_two_stage_watchdog_timer.sv
